// ===== rtl/core/b64d_pkg.sv =====
// Package with the word types, result kinds and character lookup of the base64 decoder.
package b64d_pkg;

   // Result kinds carried in out_kind.
   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_OK     = 2'd1;
   localparam logic [1:0] KIND_BADPAD = 2'd2;
   localparam logic [1:0] KIND_EMPTY  = 2'd3;

   // Pad character and the most results one input word can cause.
   localparam logic [7:0] PAD_CHAR    = 8'h3D;
   localparam int         MAX_RESULTS = 4;

   // Input word.
   typedef struct packed {
      logic [7:0] in_char;
      logic       in_last;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] out_kind;
      logic       out_last;
   } rsp_type;

   // Decoder state carried from one input word to the next.
   typedef struct packed {
      logic [17:0] sextet_group;
      logic [1:0]  group_fill;
      logic [2:0]  pad_count;
      logic        stopped;
      logic        seen_valid;
   } state_type;

   // All results caused by one input word, oldest in slot zero.
   typedef struct packed {
      rsp_type [MAX_RESULTS-1:0] words;
      logic [2:0]                count;
   } bundle_type;

   // Character classification.
   typedef struct packed {
      logic       valid;
      logic       pad;
      logic [5:0] val;
   } sextet_type;

   // Maps one character to its sextet; the pad counts as a zero sextet.
   function automatic sextet_type char_sextet(input logic [7:0] c);
      sextet_type s;
      s = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         s.valid = 1'b1;
         s.val   = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         s.valid = 1'b1;
         s.val   = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         s.valid = 1'b1;
         s.val   = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         s.valid = 1'b1;
         s.val   = 6'd62;
      end else if (c == 8'h2F) begin
         s.valid = 1'b1;
         s.val   = 6'd63;
      end else if (c == PAD_CHAR) begin
         s.valid = 1'b1;
         s.pad   = 1'b1;
      end
      return s;
   endfunction

endpackage

// ===== rtl/core/b64d_step.sv =====
// Combinational step of the base64 decoder: next state and the results of one word.
module b64d_step
   import b64d_pkg::*;
(
   input  req_type    item,
   input  state_type  cur,
   output state_type  nxt,
   output bundle_type bundle
);

   always_comb begin
      sextet_type sx;
      state_type  s1;
      logic       take;
      logic       done;
      logic [23:0] word;
      logic [2:0] em_pads;
      logic [1:0] n_bytes;
      rsp_type    status;

      sx      = char_sextet(item.in_char);
      take    = sx.valid && !cur.stopped;
      s1      = cur;
      s1.seen_valid = cur.seen_valid | sx.valid;
      done    = 1'b0;
      word    = '0;
      em_pads = '0;

      // Push the sextet of this character into the group.
      if (take) begin
         if (sx.pad && cur.pad_count != 3'd7) begin
            s1.pad_count = cur.pad_count + 3'd1;
         end
         if (cur.group_fill != 2'd3) begin
            s1.sextet_group = {cur.sextet_group[11:0], sx.val};
            s1.group_fill   = cur.group_fill + 2'd1;
         end else begin
            done            = 1'b1;
            word            = {cur.sextet_group, sx.val};
            em_pads         = s1.pad_count;
            s1.sextet_group = '0;
            s1.group_fill   = '0;
            s1.stopped      = (s1.pad_count != 3'd0);
         end
      end

      // On the final word, a partial group is completed with pads.
      if (item.in_last && !s1.stopped && s1.group_fill != 2'd0) begin
         done = 1'b1;
         case (s1.group_fill)
            2'd1: begin
               word = {s1.sextet_group[5:0], 18'd0};
            end
            2'd2: begin
               word = {s1.sextet_group[11:0], 12'd0};
            end
            default: begin
               word = {s1.sextet_group, 6'd0};
            end
         endcase
         em_pads         = s1.pad_count + (3'd4 - {1'b0, s1.group_fill});
         s1.pad_count    = em_pads;
         s1.sextet_group = '0;
         s1.group_fill   = '0;
         s1.stopped      = 1'b1;
      end

      // A completed group keeps three bytes less one per pad.
      if (done && em_pads <= 3'd2) begin
         n_bytes = 2'(3'd3 - em_pads);
      end else begin
         n_bytes = 2'd0;
      end

      // Closing status word.
      status.out_byte = 8'd0;
      status.out_last = 1'b1;
      if (!s1.seen_valid) begin
         status.out_kind = KIND_EMPTY;
      end else if (s1.pad_count >= 3'd3) begin
         status.out_kind = KIND_BADPAD;
      end else begin
         status.out_kind = KIND_OK;
      end

      // Data bytes first, then the status on the final word.
      bundle.words[0] = '{out_byte: word[23:16], out_kind: KIND_DATA, out_last: 1'b0};
      bundle.words[1] = '{out_byte: word[15:8],  out_kind: KIND_DATA, out_last: 1'b0};
      bundle.words[2] = '{out_byte: word[7:0],   out_kind: KIND_DATA, out_last: 1'b0};
      bundle.words[3] = status;
      if (item.in_last) begin
         bundle.words[n_bytes] = status;
      end
      bundle.count = {1'b0, n_bytes} + {2'b00, item.in_last};

      // A finished stream returns the state to reset.
      if (item.in_last) begin
         nxt = '0;
      end else begin
         nxt = s1;
      end
   end

endmodule

// ===== rtl/core/base64_stream_decoder_top.sv =====
// Top level of the streaming base64 decoder: input register, step logic and result queue.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_data (in_char, in_last)
//   rsp      out        rsp_valid/rsp_ready   rsp_data (out_byte, out_kind, out_last)
//
// An input word is registered, then decoded into up to four results
// (three bytes and a status) that load a four-slot result queue.
// Words with at most one result flow at one per cycle while rsp_ready is high; a word
// with n results drains one result per ready cycle, the next word loading with the last.
// Reset clears the decoder state, the input valid flag and the result count.
// A stall on rsp holds the queue and, once the input register is full, req_ready.
module base64_stream_decoder_top
   import b64d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   req_type                  req_ff;
   logic                     req_valid_ff;
   logic                     req_valid_in;
   state_type                state_ff;
   state_type                state_in;
   state_type                step_state;
   bundle_type               step_bundle;
   rsp_type [MAX_RESULTS-1:0] words_ff;
   rsp_type [MAX_RESULTS-1:0] words_in;
   logic [2:0]               count_ff;
   logic [2:0]               count_in;
   logic                     drain_ok;
   logic                     advance;

   b64d_step u_step (
      .item   (req_ff),
      .cur    (state_ff),
      .nxt    (step_state),
      .bundle (step_bundle)
   );

   // The registered word advances once the queue is empty or empties this cycle.
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = words_ff[0];
   assign drain_ok  = (count_ff == 3'd0) || (count_ff == 3'd1 && rsp_ready);
   assign advance   = req_valid_ff && drain_ok;
   assign req_ready = !req_valid_ff || advance;

   // Input register and decoder state update.
   always_comb begin
      req_valid_in = req_valid_ff;
      state_in     = state_ff;
      if (advance) begin
         state_in     = step_state;
         req_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         req_valid_in = 1'b1;
      end
   end

   // Result queue: loaded by an advancing word, shifted by each accepted result.
   always_comb begin
      words_in = words_ff;
      count_in = count_ff;
      if (advance) begin
         words_in = step_bundle.words;
         count_in = step_bundle.count;
      end else if (rsp_valid && rsp_ready) begin
         words_in = {words_ff[MAX_RESULTS-1], words_ff[MAX_RESULTS-1:1]};
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         state_ff     <= '0;
         count_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         state_ff     <= state_in;
         count_ff     <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      words_ff <= words_in;
   end

endmodule

// ===== dv/base64_stream_decoder_top_test.sv =====
// Self-checking testbench for the streaming base64 decoder top level.
`timescale 1ns / 100ps

module base64_stream_decoder_top_test
   import b64d_pkg::*;
;

   // Run limits.
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_WORDS = 400;

   // Receiver stall modes.
   localparam int RX_ALWAYS  = 0;
   localparam int RX_COIN    = 1;
   localparam int RX_SPARSE  = 2;
   localparam int RX_PATTERN = 3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   base64_stream_decoder_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Words waiting to be sent and decoded results waiting to arrive.
   req_type    pending_words[$];
   rsp_type    expected_words[$];
   logic [7:0] draft_chars[$];

   // Decoder state as predicted by the testbench.
   logic [17:0] m_group;
   logic [1:0]  m_fill;
   logic [2:0]  m_pads;
   bit          m_halted;
   bit          m_any_valid;

   // Run statistics.
   int cycle_count     = 0;
   int mismatch_count  = 0;
   int words_queued    = 0;
   int streams_queued  = 0;
   int words_accepted  = 0;
   int results_checked = 0;
   int data_bytes      = 0;
   int ends_ok         = 0;
   int ends_badpad     = 0;
   int ends_empty      = 0;

   // Classifies a character: returns 1 when it carries a sextet or is the pad.
   function automatic bit classify_char(input logic [7:0] c, output logic [5:0] v,
                                        output bit is_pad);
      v      = '0;
      is_pad = 1'b0;
      if (c >= "A" && c <= "Z") begin
         v = 6'(c - "A");
      end else if (c >= "a" && c <= "z") begin
         v = 6'(c - "a" + 8'd26);
      end else if (c >= "0" && c <= "9") begin
         v = 6'(c - "0" + 8'd52);
      end else if (c == "+") begin
         v = 6'd62;
      end else if (c == "/") begin
         v = 6'd63;
      end else if (c == PAD_CHAR) begin
         is_pad = 1'b1;
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // Encodes one sextet as its alphabet character.
   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      if (v < 6'd26) return "A" + {2'b00, v};
      if (v < 6'd52) return "a" + {2'b00, v} - 8'd26;
      if (v < 6'd62) return "0" + {2'b00, v} - 8'd52;
      if (v == 6'd62) return "+";
      return "/";
   endfunction

   // Picks a random byte that the decoder skips.
   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      logic [5:0] v;
      bit         p;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (classify_char(c, v, p));
      return c;
   endfunction

   // Adds one result to the expected stream.
   task automatic expect_result(input logic [7:0] b, input logic [1:0] kind,
                                input logic is_end);
      rsp_type e;
      e.out_byte = b;
      e.out_kind = kind;
      e.out_last = is_end;
      expected_words = {expected_words, e};
   endtask

   // Gathers one sextet; a full group releases its bytes less one per pad.
   task automatic gather_sextet(input logic [5:0] v, input bit is_pad);
      logic [23:0] full;
      int          keep;
      int          i;
      if (is_pad && m_pads < 3'd7) m_pads++;
      if (m_fill < 2'd3) begin
         m_group = {m_group[11:0], v};
         m_fill++;
      end else begin
         full = {m_group, v};
         if (m_pads <= 3'd2) begin
            keep = 3 - int'(m_pads);
            for (i = 0; i < keep; i++) expect_result(full[23-8*i -: 8], KIND_DATA, 1'b0);
         end
         m_group = '0;
         m_fill  = '0;
         if (m_pads != 3'd0) m_halted = 1'b1;
      end
   endtask

   task automatic clear_decode_state();
      m_group     = '0;
      m_fill      = '0;
      m_pads      = '0;
      m_halted    = 1'b0;
      m_any_valid = 1'b0;
   endtask

   // Works out every result that one accepted word causes.
   task automatic predict_word(input req_type w);
      logic [5:0] v;
      bit         is_pad;
      logic [1:0] kind;
      if (classify_char(w.in_char, v, is_pad)) begin
         m_any_valid = 1'b1;
         if (!m_halted) gather_sextet(v, is_pad);
      end
      if (w.in_last) begin
         if (!m_halted) begin
            while (m_fill != 2'd0) gather_sextet(6'd0, 1'b1);
         end
         if (!m_any_valid) kind = KIND_EMPTY;
         else if (m_pads >= 3'd3) kind = KIND_BADPAD;
         else kind = KIND_OK;
         expect_result(8'h00, kind, 1'b1);
         clear_decode_state();
      end
   endtask

   // Queues one word for the driver.
   task automatic queue_word(input logic [7:0] c, input bit is_end);
      req_type w;
      w.in_char = c;
      w.in_last = is_end;
      pending_words = {pending_words, w};
      words_queued++;
      if (is_end) streams_queued++;
   endtask

   task automatic queue_text(input string s, input bit ends);
      int i;
      for (i = 0; i < s.len(); i++) queue_word(s[i], ends && i == s.len() - 1);
   endtask

   // Encodes random bytes into the draft, with or without trailing pads.
   task automatic draft_valid_bytes(input int nbytes, input bit keep_pads);
      logic [23:0] trio;
      int          n;
      int          k;
      while (nbytes > 0) begin
         n    = (nbytes > 3) ? 3 : nbytes;
         trio = 24'($urandom);
         if (n < 3) trio[7:0] = 8'h00;
         if (n < 2) trio[15:8] = 8'h00;
         for (k = 0; k <= n; k++) begin
            draft_chars = {draft_chars, sextet_char(trio[23-6*k -: 6])};
         end
         if (keep_pads) begin
            for (k = n + 1; k < 4; k++) draft_chars = {draft_chars, PAD_CHAR};
         end
         nbytes -= n;
      end
   endtask

   // Sends the draft as one stream, sprinkling skipped bytes in between.
   task automatic flush_draft(input int junk_pct);
      bit trailing;
      trailing = (draft_chars.size() == 0) || ($urandom_range(0, 9) == 0);
      foreach (draft_chars[i]) begin
         if ($urandom_range(0, 99) < junk_pct) queue_word(junk_char(), 1'b0);
         queue_word(draft_chars[i], !trailing && i == draft_chars.size() - 1);
      end
      if (trailing) queue_word(junk_char(), 1'b1);
      draft_chars.delete();
   endtask

   // Builds one random stream; most are well formed, the rest broken or noise.
   task automatic queue_random_stream();
      int pick;
      int k;
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
         draft_valid_bytes(($urandom_range(0, 7) == 0) ? $urandom_range(8, 24)
                                                       : $urandom_range(0, 7),
                           $urandom_range(0, 3) != 0);
         flush_draft(($urandom_range(0, 2) == 0) ? 20 : 0);
      end else if (pick == 6) begin
         repeat ($urandom_range(1, 10)) begin
            draft_chars = {draft_chars, 8'($urandom_range(0, 255))};
         end
         flush_draft(0);
      end else if (pick == 7) begin
         // A group with three or four pads, then characters that must be ignored.
         draft_valid_bytes(3 * $urandom_range(0, 2), 1'b1);
         draft_chars = {draft_chars, ($urandom_range(0, 1) == 0) ? PAD_CHAR
                                                                 : sextet_char(6'($urandom))};
         repeat (3) draft_chars = {draft_chars, PAD_CHAR};
         repeat ($urandom_range(0, 4)) begin
            draft_chars = {draft_chars, sextet_char(6'($urandom))};
         end
         flush_draft(10);
      end else if (pick == 8) begin
         // Pads at random places inside a group, then a tail after the stop.
         draft_valid_bytes(3 * $urandom_range(0, 2), 1'b1);
         for (k = 0; k < 4; k++) begin
            draft_chars = {draft_chars, ($urandom_range(0, 3) == 0) ? PAD_CHAR
                                                                    : sextet_char(6'($urandom))};
         end
         repeat ($urandom_range(0, 5)) begin
            draft_chars = {draft_chars, sextet_char(6'($urandom))};
         end
         flush_draft(10);
      end else begin
         repeat ($urandom_range(0, 3)) draft_chars = {draft_chars, junk_char()};
         flush_draft(0);
      end
   endtask

   // Waits until nothing is left to send and every expected result has come.
   task automatic wait_for_drain();
      while (pending_words.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
   endtask

   task automatic report_mismatch(input string field, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s differs: expected byte=%h kind=%0d last=%0d, got byte=%h kind=%0d last=%0d",
                  $time, field, want.out_byte, want.out_kind, want.out_last,
                  got.out_byte, got.out_kind, got.out_last);
      end
   endtask

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, expected_words.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Driver: sends queued words in bursts separated by random gaps.
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         req_data   <= '0;
         burst_left <= 1;
         gap_left   <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_word(req_data);
            words_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_data  <= pending_words.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: the stall mode and its pattern change whenever the 6-bit mode timer wraps.
   int         ready_mode;
   logic [5:0] mode_timer;
   logic [7:0] stall_pattern;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready     <= 1'b0;
         ready_mode    <= RX_ALWAYS;
         mode_timer    <= '0;
         stall_pattern <= 8'hFF;
      end else begin
         mode_timer <= mode_timer + 6'd1;
         if (mode_timer == 6'd0) begin
            ready_mode    <= $urandom_range(RX_ALWAYS, RX_PATTERN);
            stall_pattern <= 8'($urandom) | 8'h01;
         end else begin
            stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
         end
         case (ready_mode)
            RX_ALWAYS: rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_ready <= stall_pattern[0];
         endcase
      end
   end

   // Monitor: each result word is compared with the oldest expectation.
   rsp_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected result", '0, rsp_data);
         end else begin
            want = expected_words.pop_front();
            results_checked++;
            if (rsp_data.out_byte !== want.out_byte) report_mismatch("out_byte", want, rsp_data);
            if (rsp_data.out_kind !== want.out_kind) report_mismatch("out_kind", want, rsp_data);
            if (rsp_data.out_last !== want.out_last) report_mismatch("out_last", want, rsp_data);
            if (want.out_kind == KIND_DATA) data_bytes++;
            else if (want.out_kind == KIND_OK) ends_ok++;
            else if (want.out_kind == KIND_BADPAD) ends_badpad++;
            else ends_empty++;
         end
      end
   end

   // Stimulus sequence and end of run.
   initial begin
      int directed_count;
      clear_decode_state();

      // Directed streams: full group, one pad, stop with ignored tail,
      // partial groups at the end, skipped bytes only, and bad padding.
      queue_text("TWFu", 1'b0);
      queue_text("+/9=", 1'b1);
      queue_text("TQ==QQ", 1'b1);
      queue_text("QU", 1'b1);
      queue_word(8'hFF, 1'b0);
      queue_word(8'h00, 1'b0);
      queue_word(8'h80, 1'b1);
      queue_text("A===", 1'b1);
      queue_text("z", 1'b1);
      directed_count = words_queued;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait_for_drain();

      // Random streams in two halves; the sender holds off until the first drains.
      while (words_queued < directed_count + RANDOM_WORDS / 2) queue_random_stream();
      wait_for_drain();
      while (words_queued < directed_count + RANDOM_WORDS) queue_random_stream();
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d words in %0d streams and %0d checked results (%0d data bytes).",
               words_accepted, streams_queued, results_checked, data_bytes);
      $display("Stream endings: %0d ok, %0d bad padding, %0d empty; %0d field errors.",
               ends_ok, ends_badpad, ends_empty, mismatch_count);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
